// ===== rtl/set_assoc_cache_controller_defines.svh =====
// ============================================================================
// Set-associative cache controller: assertion macros
// Concurrent checks on the clock, disabled while reset is low.
// ============================================================================
`ifndef SET_ASSOC_CACHE_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_CACHE_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define SCC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scc_pkg.sv =====
// ============================================================================
// scc_pkg
// Shared constants, register codes and helper types of the cache controller.
// ============================================================================
package scc_pkg;

    localparam int WAYS_DEF     = 4;
    localparam int SETS_DEF     = 64;
    localparam int AGE_BITS_DEF = 16;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int OUT_WAY_W  = 2;
    localparam int CNT_W      = 32;
    localparam int LFSR_W     = 16;
    localparam int OFFSET_W   = 5;
    localparam int SETB_W     = 3;
    localparam int SHIFT_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int RND_SHIFT  = 20;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

    localparam logic [SETB_W-1:0] SET_BITS_RST = 3'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WB_MODE     = 3'd0,
        CFG_RND_REPL    = 3'd1,
        CFG_OFFSET_BITS = 3'd2,
        CFG_SET_BITS    = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic hit;
        logic alloc;
        logic main_read;
        logic main_write;
        logic lfsr_step;
    } t_lookup;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
    endfunction

endpackage

// ===== rtl/set_assoc_cache_controller.sv =====
// ============================================================================
// set_assoc_cache_controller
// Set-associative cache directory with LRU or LFSR replacement, write-through
// or write-back policy, and six running event counters.
// ============================================================================
// Each request first reads the set row from the tag RAM, then updates tags,
// ages and dirty bits, writes the row back and loads the result register.
// The tag RAM read is registered, and a new request is taken only once the
// previous one has written its row back. A request whose result cannot be
// loaded because the previous result is still stalled waits in the update
// step. After reset every set of the tag RAM is cleared, one set per cycle,
// and no request is taken during that pass; configuration writes are taken at any time.
module set_assoc_cache_controller #(
    parameter int WAYS     = scc_pkg::WAYS_DEF,
    parameter int SETS     = scc_pkg::SETS_DEF,
    parameter int AGE_BITS = scc_pkg::AGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [scc_pkg::ADDR_W-1:0]    i_address,
    input  logic                          i_action,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [scc_pkg::OUT_WAY_W-1:0] o_way,
    output logic                          o_main_read,
    output logic                          o_main_write,
    output logic [scc_pkg::CNT_W-1:0]     o_read_hits,
    output logic [scc_pkg::CNT_W-1:0]     o_read_misses,
    output logic [scc_pkg::CNT_W-1:0]     o_write_hits,
    output logic [scc_pkg::CNT_W-1:0]     o_write_misses,
    output logic [scc_pkg::CNT_W-1:0]     o_main_reads_total,
    output logic [scc_pkg::CNT_W-1:0]     o_main_writes_total,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [scc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

`include "set_assoc_cache_controller_defines.svh"

    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W  = 2 + AGE_BITS + scc_pkg::TAG_W;
    localparam int ROW_W   = WAYS * LINE_W;
    localparam int LFSR_W  = scc_pkg::LFSR_W;
    localparam int CNT_W   = scc_pkg::CNT_W;
    localparam int RECIP_W = scc_pkg::RND_SHIFT + 1;
    localparam int PROD_W  = RECIP_W + LFSR_W;
    localparam logic [RECIP_W-1:0] RND_RECIP =
        RECIP_W'((2 ** scc_pkg::RND_SHIFT + WAYS - 1) / WAYS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    t_state                         r_state;
    logic [SET_W-1:0]               r_clr;
    logic [SET_W-1:0]               r_set;
    logic [scc_pkg::TAG_W-1:0]      r_tag;
    logic                           r_write;
    logic                           r_wb_mode;
    logic                           r_rnd_mode;
    logic [scc_pkg::OFFSET_W-1:0]   r_offset_bits;
    logic [scc_pkg::SETB_W-1:0]     r_set_bits;
    logic [LFSR_W-1:0]              r_lfsr;
    logic [LFSR_W-1:0]              r_rnd_q;
    logic                           r_out_valid;
    logic                           r_hit;
    logic [scc_pkg::OUT_WAY_W-1:0]  r_way;
    logic                           r_mread;
    logic                           r_mwrite;
    logic [CNT_W-1:0]               r_rh;
    logic [CNT_W-1:0]               r_rm;
    logic [CNT_W-1:0]               r_wh;
    logic [CNT_W-1:0]               r_wm;
    logic [CNT_W-1:0]               r_mrt;
    logic [CNT_W-1:0]               r_mwt;

    logic                           w_accept;
    logic                           w_proceed;
    logic [SET_W-1:0]               w_set;
    logic [scc_pkg::TAG_W-1:0]      w_tag;
    logic                           w_ram_we;
    logic [SET_W-1:0]               w_ram_waddr;
    logic [ROW_W-1:0]               w_ram_wdata;
    logic [ROW_W-1:0]               w_row;
    logic [ROW_W-1:0]               w_new_row;
    logic [WAY_W-1:0]               w_way;
    scc_pkg::t_lookup               w_res;
    logic [LFSR_W-1:0]              w_lfsr_step;
    logic [PROD_W-1:0]              w_rnd_prod;
    logic [LFSR_W-1:0]              w_rnd_rem;
    logic [WAY_W-1:0]               w_rnd_way;
    logic [CNT_W-1:0]               w_access_sum;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_proceed   = (r_state == S_LOOKUP) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_ram_we    = (r_state == S_CLEAR) || w_proceed;
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr : r_set;
    assign w_ram_wdata = (r_state == S_CLEAR) ? '0 : w_new_row;

    assign w_lfsr_step = scc_pkg::lfsr_next(r_lfsr);
    assign w_rnd_prod  = PROD_W'(w_lfsr_step) * PROD_W'(RND_RECIP);
    assign w_rnd_rem   = w_lfsr_step - LFSR_W'(r_rnd_q * LFSR_W'(WAYS));
    assign w_rnd_way   = w_rnd_rem[WAY_W-1:0];

    assign w_access_sum = r_rh + r_rm + r_wh + r_wm;

    scc_addr #(
        .SETS (SETS)
    ) u_addr (
        .i_address     (i_address),
        .i_offset_bits (r_offset_bits),
        .i_set_bits    (r_set_bits),
        .o_set         (w_set),
        .o_tag         (w_tag)
    );

    scc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (w_set),
        .o_rdata (w_row)
    );

    scc_lookup #(
        .WAYS     (WAYS),
        .AGE_BITS (AGE_BITS)
    ) u_lookup (
        .i_row      (w_row),
        .i_tag      (r_tag),
        .i_write    (r_write),
        .i_wb_mode  (r_wb_mode),
        .i_rnd_mode (r_rnd_mode),
        .i_rnd_way  (w_rnd_way),
        .o_row      (w_new_row),
        .o_way      (w_way),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_wb_mode     <= 1'b0;
            r_rnd_mode    <= 1'b0;
            r_offset_bits <= '0;
            r_set_bits    <= scc_pkg::SET_BITS_RST;
            r_lfsr        <= scc_pkg::LFSR_SEED;
            r_out_valid   <= 1'b0;
            r_rh          <= '0;
            r_rm          <= '0;
            r_wh          <= '0;
            r_wm          <= '0;
            r_mrt         <= '0;
            r_mwt         <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (scc_pkg::t_cfg_idx'(i_cfg_index))
                    scc_pkg::CFG_WB_MODE:     r_wb_mode     <= i_cfg_data[0];
                    scc_pkg::CFG_RND_REPL:    r_rnd_mode    <= i_cfg_data[0];
                    scc_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[scc_pkg::OFFSET_W-1:0];
                    scc_pkg::CFG_SET_BITS:    r_set_bits    <= i_cfg_data[scc_pkg::SETB_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && !w_proceed) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SET_W'(1);
                    if (r_clr == SET_W'(SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    if (w_proceed) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_hit       <= w_res.hit;
                        r_way       <= scc_pkg::OUT_WAY_W'(w_way);
                        r_mread     <= w_res.main_read;
                        r_mwrite    <= w_res.main_write;
                        if (w_res.lfsr_step) begin
                            r_lfsr <= w_lfsr_step;
                        end
                        if (w_res.hit && !r_write) begin
                            r_rh <= r_rh + CNT_W'(1);
                        end
                        if (!w_res.hit && !r_write) begin
                            r_rm <= r_rm + CNT_W'(1);
                        end
                        if (w_res.hit && r_write) begin
                            r_wh <= r_wh + CNT_W'(1);
                        end
                        if (!w_res.hit && r_write) begin
                            r_wm <= r_wm + CNT_W'(1);
                        end
                        if (w_res.main_read) begin
                            r_mrt <= r_mrt + CNT_W'(1);
                        end
                        if (w_res.main_write) begin
                            r_mwt <= r_mwt + CNT_W'(1);
                        end
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd_q <= w_rnd_prod[scc_pkg::RND_SHIFT +: LFSR_W];
        if (w_accept) begin
            r_set   <= w_set;
            r_tag   <= w_tag;
            r_write <= i_action;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_hit               = r_hit;
    assign o_way               = r_way;
    assign o_main_read         = r_mread;
    assign o_main_write        = r_mwrite;
    assign o_read_hits         = r_rh;
    assign o_read_misses       = r_rm;
    assign o_write_hits        = r_wh;
    assign o_write_misses      = r_wm;
    assign o_main_reads_total  = r_mrt;
    assign o_main_writes_total = r_mwt;

    `SCC_ASSERT_NEXT(a_one_access_count, i_clk, i_rst_n, w_proceed,
        w_access_sum == $past(w_access_sum) + CNT_W'(1), "access counters off by one")
    `SCC_ASSERT_NEXT(a_main_read_count, i_clk, i_rst_n, w_proceed,
        r_mrt == $past(r_mrt) + CNT_W'(r_mread), "main read counter mismatch")
    `SCC_ASSERT_NOW(a_hit_no_fetch, i_clk, i_rst_n, r_out_valid,
        !(r_hit && r_mread), "hit with a block fetch")
    `SCC_ASSERT_NOW(a_lfsr_nonzero, i_clk, i_rst_n, r_state != S_CLEAR,
        r_lfsr != '0, "LFSR locked at zero")

endmodule

// ===== rtl/scc_ram.sv =====
// ============================================================================
// scc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module scc_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/scc_addr.sv =====
// ============================================================================
// scc_addr
// Address split: skip the block offset, extract set index and tag.
// ============================================================================
module scc_addr #(
    parameter  int SETS  = scc_pkg::SETS_DEF,
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic [scc_pkg::ADDR_W-1:0]   i_address,
    input  logic [scc_pkg::OFFSET_W-1:0] i_offset_bits,
    input  logic [scc_pkg::SETB_W-1:0]   i_set_bits,
    output logic [SET_W-1:0]             o_set,
    output logic [scc_pkg::TAG_W-1:0]    o_tag
);

    localparam int MAX_SB = $clog2(SETS + 1) - 1;

    logic [scc_pkg::SETB_W-1:0]  sb;
    logic [scc_pkg::ADDR_W-1:0]  shifted;
    logic [scc_pkg::ADDR_W-1:0]  mask;
    logic [scc_pkg::SHIFT_W-1:0] total;

    always_comb begin
        sb = i_set_bits;
        if (int'(i_set_bits) > MAX_SB) begin
            sb = scc_pkg::SETB_W'(MAX_SB);
        end
        shifted = i_address >> i_offset_bits;
        mask    = (scc_pkg::ADDR_W'(1) << sb) - scc_pkg::ADDR_W'(1);
        o_set   = SET_W'(shifted & mask);
        total   = scc_pkg::SHIFT_W'(i_offset_bits) + scc_pkg::SHIFT_W'(sb);
        o_tag   = (total >= scc_pkg::SHIFT_W'(scc_pkg::TAG_W)) ? '0
                : scc_pkg::TAG_W'(i_address >> total);
    end

endmodule

// ===== rtl/scc_lookup.sv =====
// ============================================================================
// scc_lookup
// Set update: tag match, aging, victim choice and the row to write back.
// ============================================================================
module scc_lookup #(
    parameter  int WAYS     = scc_pkg::WAYS_DEF,
    parameter  int AGE_BITS = scc_pkg::AGE_BITS_DEF,
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int LINE_W   = 2 + AGE_BITS + scc_pkg::TAG_W,
    localparam int ROW_W    = WAYS * LINE_W
) (
    input  logic [ROW_W-1:0]          i_row,
    input  logic [scc_pkg::TAG_W-1:0] i_tag,
    input  logic                      i_write,
    input  logic                      i_wb_mode,
    input  logic                      i_rnd_mode,
    input  logic [WAY_W-1:0]          i_rnd_way,
    output logic [ROW_W-1:0]          o_row,
    output logic [WAY_W-1:0]          o_way,
    output scc_pkg::t_lookup          o_res
);

    localparam int TAG_W = scc_pkg::TAG_W;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    logic                vld   [WAYS];
    logic                drt   [WAYS];
    logic [AGE_BITS-1:0] aged  [WAYS];
    logic [TAG_W-1:0]    tg    [WAYS];
    logic                n_vld [WAYS];
    logic                n_drt [WAYS];
    logic [AGE_BITS-1:0] n_age [WAYS];
    logic [TAG_W-1:0]    n_tg  [WAYS];

    logic                hit_f;
    logic [WAY_W-1:0]    hit_w;
    logic                inv_f;
    logic [WAY_W-1:0]    inv_w;
    logic [WAY_W-1:0]    best_w;
    logic [AGE_BITS-1:0] best_age;
    logic [WAY_W-1:0]    victim;
    logic                alloc;
    logic                wb_write;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            vld[w]  = i_row[w*LINE_W + LINE_W - 1];
            drt[w]  = i_row[w*LINE_W + LINE_W - 2];
            tg[w]   = i_row[w*LINE_W +: TAG_W];
            aged[w] = i_row[w*LINE_W + TAG_W +: AGE_BITS];
            if (vld[w] && aged[w] != AGE_MAX) begin
                aged[w] = aged[w] + AGE_BITS'(1);
            end
        end

        hit_f = 1'b0;
        hit_w = '0;
        inv_f = 1'b0;
        inv_w = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit_f && vld[w] && tg[w] == i_tag) begin
                hit_f = 1'b1;
                hit_w = WAY_W'(w);
            end
            if (!inv_f && !vld[w]) begin
                inv_f = 1'b1;
                inv_w = WAY_W'(w);
            end
        end

        best_w   = '0;
        best_age = aged[0];
        for (int w = 1; w < WAYS; w++) begin
            if (aged[w] > best_age) begin
                best_age = aged[w];
                best_w   = WAY_W'(w);
            end
        end

        alloc  = !hit_f && !(i_write && !i_wb_mode);
        victim = inv_f ? inv_w : (i_rnd_mode ? i_rnd_way : best_w);

        wb_write = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            n_vld[w] = vld[w];
            n_drt[w] = drt[w];
            n_age[w] = aged[w];
            n_tg[w]  = tg[w];
            if (hit_f && hit_w == WAY_W'(w)) begin
                n_age[w] = '0;
                if (i_write && i_wb_mode) begin
                    n_drt[w] = 1'b1;
                end
            end
            if (alloc && victim == WAY_W'(w)) begin
                wb_write = i_wb_mode && vld[w] && drt[w];
                n_vld[w] = 1'b1;
                n_drt[w] = i_write && i_wb_mode;
                n_age[w] = '0;
                n_tg[w]  = i_tag;
            end
            o_row[w*LINE_W +: LINE_W] = {n_vld[w], n_drt[w], n_age[w], n_tg[w]};
        end

        o_res.hit        = hit_f;
        o_res.alloc      = alloc;
        o_res.main_read  = !hit_f && (!i_write || i_wb_mode);
        o_res.main_write = (i_write && !i_wb_mode) || wb_write;
        o_res.lfsr_step  = alloc && !inv_f && i_rnd_mode;
        o_way            = hit_f ? hit_w : (alloc ? victim : '0);
    end

endmodule
